/* design/asel_pkg.sv */
// Shared types and constants for the audio source selector.
// No dependencies; every other design file imports this package.
package asel_pkg;

  // Channel and field widths
  localparam int NUM_CHANNELS      = 4;
  localparam int MEASURED_CHANNELS = 3;
  localparam int LEVEL_BITS        = 10;
  localparam int CH_BITS           = 3;
  localparam int HOLD_BITS         = 16;
  localparam int VOL_BITS          = 8;
  localparam int CODE_BITS         = 8;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEVEL_THRESHOLD = 3'd0,
    CFG_AMP_HOLD_TICKS  = 3'd1,
    CFG_VOLUME_MIN      = 3'd2,
    CFG_VOLUME_MAX      = 3'd3,
    CFG_VOLUME_START    = 3'd4
  } cfg_index_t;

  // Register reset values
  localparam logic [LEVEL_BITS-1:0] LEVEL_THRESHOLD_RST = 10'd100;
  localparam logic [HOLD_BITS-1:0]  AMP_HOLD_TICKS_RST  = 16'd60;
  localparam logic [VOL_BITS-1:0]   VOLUME_MIN_RST      = 8'd23;
  localparam logic [VOL_BITS-1:0]   VOLUME_MAX_RST      = 8'd60;
  localparam logic [VOL_BITS-1:0]   VOLUME_START_RST    = 8'd45;

  // Current channel code for "no channel selected"
  localparam logic [CH_BITS-1:0] NO_CHANNEL = 3'd4;

  // Word kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REMOTE = 1'b1;

  // IR remote command codes
  localparam logic [CODE_BITS-1:0] CODE_MENU  = 8'h02;
  localparam logic [CODE_BITS-1:0] CODE_PLAY  = 8'h04;
  localparam logic [CODE_BITS-1:0] CODE_FWD   = 8'h07;
  localparam logic [CODE_BITS-1:0] CODE_REW   = 8'h08;
  localparam logic [CODE_BITS-1:0] CODE_PLUS  = 8'h0B;
  localparam logic [CODE_BITS-1:0] CODE_MINUS = 8'h0D;

  typedef struct packed {
    logic                  kind;
    logic [LEVEL_BITS-1:0] level_a;
    logic [LEVEL_BITS-1:0] level_b;
    logic [LEVEL_BITS-1:0] level_c;
    logic [CODE_BITS-1:0]  remote_code;
  } in_item_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] relay_mask;
    logic                    amp_enable;
    logic [CH_BITS-1:0]      selected_channel;
    logic [VOL_BITS-1:0]     volume_position;
    logic                    paused;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_threshold;
    logic [HOLD_BITS-1:0]  amp_hold_ticks;
    logic [VOL_BITS-1:0]   volume_min;
    logic [VOL_BITS-1:0]   volume_max;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] active_mask;
    logic [NUM_CHANNELS-1:0] previous_mask;
    logic [CH_BITS-1:0]      current_channel;
    logic [NUM_CHANNELS-1:0] relays;
    logic                    amp_on;
    logic                    pause_flag;
    logic [HOLD_BITS-1:0]    hold_counter;
    logic [VOL_BITS-1:0]     volume;
    logic [VOL_BITS-1:0]     saved_volume;
  } state_t;

endpackage

/* design/asel_if.sv */
// Valid/ready stream interfaces for the selector's input and result words.
// Depends on asel_pkg for the payload structs.
interface asel_in_if;
  import asel_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asel_out_if;
  import asel_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/audio_source_selector.sv */
// Audio source selector: an input register feeds a state register that also drives
// the result word. Throughput one word per cycle while the result side takes words;
// the state update is a single combinational pass.
// Synchronous active-low reset empties both stages, loads the register defaults,
// clears all relays and the amp, selects no channel and sets the volume to 45.
// Depends on asel_pkg, asel_if and asel_core.
module audio_source_selector (
  input  logic                                clk,
  input  logic                                rst_n,
  asel_in_if.sink                             in_ch,
  asel_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [asel_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [asel_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import asel_pkg::*;

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  state_t   state_r;
  state_t   state_nxt;
  cfg_t     cfg_r;
  logic     advance;

  // Move the held word into the state register when the result side frees up
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  asel_core u_core (
    .st     (state_r),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt)
  );

  // Control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '{
        active_mask:     '0,
        previous_mask:   '0,
        current_channel: NO_CHANNEL,
        relays:          '0,
        amp_on:          1'b0,
        pause_flag:      1'b0,
        hold_counter:    '0,
        volume:          VOLUME_START_RST,
        saved_volume:    VOLUME_START_RST
      };
      cfg_r <= '{
        level_threshold: LEVEL_THRESHOLD_RST,
        amp_hold_ticks:  AMP_HOLD_TICKS_RST,
        volume_min:      VOLUME_MIN_RST,
        volume_max:      VOLUME_MAX_RST
      };
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
      // volume_start only matters at reset, where its default is used
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEVEL_THRESHOLD: cfg_r.level_threshold <= cfg_wdata[LEVEL_BITS-1:0];
          CFG_AMP_HOLD_TICKS:  cfg_r.amp_hold_ticks  <= cfg_wdata[HOLD_BITS-1:0];
          CFG_VOLUME_MIN:      cfg_r.volume_min      <= cfg_wdata[VOL_BITS-1:0];
          CFG_VOLUME_MAX:      cfg_r.volume_max      <= cfg_wdata[VOL_BITS-1:0];
          CFG_VOLUME_START:    cfg_r <= cfg_r;
          default:             cfg_r <= cfg_r;
        endcase
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.data;
    end
  end

  // Result word shows the state after the last processed item
  assign out_ch.valid                 = out_valid_r;
  assign out_ch.data.relay_mask       = state_r.relays;
  assign out_ch.data.amp_enable       = state_r.amp_on;
  assign out_ch.data.selected_channel = state_r.current_channel;
  assign out_ch.data.volume_position  = state_r.volume;
  assign out_ch.data.paused           = state_r.pause_flag;

endmodule

/* design/asel_core.sv */
// Next-state logic of the selector: one tick or remote word against the current state.
// Depends on asel_pkg for the state, configuration and word structs.
module asel_core (
  input  asel_pkg::state_t   st,
  input  asel_pkg::in_item_t item,
  input  asel_pkg::cfg_t     cfg,
  output asel_pkg::state_t   st_nxt
);
  import asel_pkg::*;

  // Highest set bit, NO_CHANNEL when empty
  function automatic logic [CH_BITS-1:0] highest_bit(logic [NUM_CHANNELS-1:0] m);
    logic [CH_BITS-1:0] n;
    n = NO_CHANNEL;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (m[k]) n = CH_BITS'(k);
    end
    return n;
  endfunction

  // Lowest set bit, NO_CHANNEL when empty
  function automatic logic [CH_BITS-1:0] lowest_bit(logic [NUM_CHANNELS-1:0] m);
    logic [CH_BITS-1:0] n;
    n = NO_CHANNEL;
    for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
      if (m[k]) n = CH_BITS'(k);
    end
    return n;
  endfunction

  logic [NUM_CHANNELS-1:0] lvl_mask;
  logic [NUM_CHANNELS-1:0] chg_mask;
  logic [NUM_CHANNELS-1:0] fresh_mask;
  logic [CH_BITS-1:0]      tick_pick;
  logic [NUM_CHANNELS-1:0] below_mask;
  logic [NUM_CHANNELS-1:0] above_mask;
  logic [CH_BITS-1:0]      rew_pick;
  logic [CH_BITS-1:0]      fwd_pick;
  logic [CH_BITS-1:0]      menu_pick;
  logic                    cur_valid;
  logic [VOL_BITS-1:0]     vol_up;
  logic [VOL_BITS-1:0]     vol_dn;

  // Compare levels and build the channel picks
  always_comb begin
    lvl_mask    = '0;
    lvl_mask[0] = item.level_a > cfg.level_threshold;
    lvl_mask[1] = item.level_b > cfg.level_threshold;
    lvl_mask[2] = item.level_c > cfg.level_threshold;
    chg_mask    = lvl_mask ^ st.previous_mask;
    fresh_mask  = chg_mask & lvl_mask;
    tick_pick   = (fresh_mask != '0) ? highest_bit(fresh_mask) : highest_bit(lvl_mask);

    cur_valid = st.current_channel < NO_CHANNEL;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      below_mask[k] = st.active_mask[k] && (CH_BITS'(k) < st.current_channel);
      above_mask[k] = st.active_mask[k] && (CH_BITS'(k) > st.current_channel);
    end
    rew_pick  = highest_bit(below_mask);
    fwd_pick  = lowest_bit(above_mask);
    menu_pick = highest_bit(st.active_mask);
    vol_up    = st.volume + 1'b1;
    vol_dn    = st.volume - 1'b1;
  end

  // Apply the word to the state
  always_comb begin
    st_nxt = st;
    if (item.kind == KIND_TICK) begin
      st_nxt.active_mask   = lvl_mask;
      st_nxt.previous_mask = lvl_mask;
      // drop the current relay and pick again on a mask change
      if (chg_mask != '0) begin
        if (cur_valid) begin
          st_nxt.relays[st.current_channel[1:0]] = 1'b0;
          st_nxt.current_channel                 = NO_CHANNEL;
        end
        if (lvl_mask == '0) begin
          st_nxt.relays = '0;
        end else begin
          st_nxt.relays[tick_pick[1:0]] = 1'b1;
          st_nxt.hold_counter           = cfg.amp_hold_ticks;
          st_nxt.current_channel        = tick_pick;
        end
      end
      // reload or count down the amp hold
      if (lvl_mask != '0 && st.amp_on) begin
        st_nxt.hold_counter = cfg.amp_hold_ticks;
      end else if (st_nxt.hold_counter != '0) begin
        st_nxt.hold_counter = st_nxt.hold_counter - 1'b1;
      end
      if (st_nxt.hold_counter != '0) begin
        st_nxt.amp_on = 1'b1;
      end else begin
        st_nxt.amp_on = 1'b0;
        st_nxt.relays = '0;
      end
    end else begin
      unique case (item.remote_code)
        CODE_REW: begin
          if (cur_valid && below_mask != '0) begin
            st_nxt.relays[st.current_channel[1:0]] = 1'b0;
            st_nxt.relays[rew_pick[1:0]]           = 1'b1;
            st_nxt.hold_counter                    = cfg.amp_hold_ticks;
            st_nxt.current_channel                 = rew_pick;
          end
        end
        CODE_FWD: begin
          if (cur_valid && above_mask != '0) begin
            st_nxt.relays[st.current_channel[1:0]] = 1'b0;
            st_nxt.relays[fwd_pick[1:0]]           = 1'b1;
            st_nxt.hold_counter                    = cfg.amp_hold_ticks;
            st_nxt.current_channel                 = fwd_pick;
          end
        end
        CODE_PLUS: begin
          st_nxt.pause_flag = 1'b0;
          if (st.volume < cfg.volume_max) begin
            st_nxt.volume       = vol_up;
            st_nxt.saved_volume = vol_up;
          end
        end
        CODE_MINUS: begin
          st_nxt.pause_flag = 1'b0;
          if (st.volume > cfg.volume_min) begin
            st_nxt.volume       = vol_dn;
            st_nxt.saved_volume = vol_dn;
          end
        end
        CODE_PLAY: begin
          if (st.pause_flag) begin
            st_nxt.pause_flag = 1'b0;
            st_nxt.volume     = st.saved_volume;
          end else begin
            st_nxt.pause_flag   = 1'b1;
            st_nxt.saved_volume = st.volume;
            st_nxt.volume       = cfg.volume_min;
          end
        end
        CODE_MENU: begin
          // toggle the amp; switching on needs an active channel
          if (st.amp_on) begin
            st_nxt.amp_on       = 1'b0;
            st_nxt.hold_counter = '0;
          end else if (st.active_mask != '0) begin
            st_nxt.amp_on                 = 1'b1;
            st_nxt.relays[menu_pick[1:0]] = 1'b1;
            st_nxt.hold_counter           = cfg.amp_hold_ticks;
            st_nxt.current_channel        = menu_pick;
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

/* design/asel_chk.sv */
// Port-level checks for audio_source_selector, attached by bind.
// Depends on asel_pkg for the result word layout.
module asel_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input asel_pkg::out_item_t out_data
);
  import asel_pkg::*;

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Selected channel is a real channel or none
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.selected_channel <= NO_CHANNEL)
    else $error("selected channel out of range");

  // The unmeasured channel never gets its relay closed
  a_no_relay3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.relay_mask[NUM_CHANNELS-1])
    else $error("relay of unmeasured channel closed");

  // A stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

bind audio_source_selector asel_chk u_asel_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* test/tb_audio_source_selector.sv */
// Self-checking testbench for audio_source_selector: directed table, then random words.
// Depends on asel_pkg, asel_if and the selector RTL; predicts each untyped result word.
module tb_audio_source_selector;
  timeunit 1ns;
  timeprecision 1ps;
  import asel_pkg::*;

  // Remote code that no command uses
  localparam logic [CODE_BITS-1:0] CODE_UNUSED = 8'hFF;
  localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = '1;

  typedef struct packed {
    logic                  kind;
    logic [LEVEL_BITS-1:0] lv_a;
    logic [LEVEL_BITS-1:0] lv_b;
    logic [LEVEL_BITS-1:0] lv_c;
    logic [CODE_BITS-1:0]  code;
    logic                  typed;
    out_item_t             want;
  } stim_row_t;

  typedef struct packed {
    logic      typed;
    out_item_t want;
  } word_plan_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] thr;
    logic [HOLD_BITS-1:0]  hold;
    logic [VOL_BITS-1:0]   vmin;
    logic [VOL_BITS-1:0]   vmax;
    logic [VOL_BITS-1:0]   vstart;
  } reg_set_t;

  localparam out_item_t AT_RESET   = '{4'b0000, 1'b0, NO_CHANNEL, VOLUME_START_RST, 1'b0};
  localparam out_item_t ALL_ACTIVE = '{4'b0100, 1'b1, 3'd2, VOLUME_START_RST, 1'b0};

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{KIND_TICK,   10'd0, 10'd0, 10'd0, CODE_UNUSED, 1'b1, AT_RESET},
    '{KIND_REMOTE, LEVEL_TOP, LEVEL_TOP, LEVEL_TOP, CODE_MENU, 1'b1, AT_RESET},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_REW, 1'b1, AT_RESET},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_FWD, 1'b1, AT_RESET},
    '{KIND_TICK,   LEVEL_TOP, LEVEL_TOP, LEVEL_TOP, CODE_UNUSED, 1'b1, ALL_ACTIVE},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_REW, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_REW, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_REW, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_FWD, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_FWD, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_FWD, 1'b0, '0},
    '{KIND_TICK,   10'd0, LEVEL_TOP, 10'd0, CODE_PLAY, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_FWD, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_REW, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_PLAY, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_PLUS, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_PLAY, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_PLAY, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_MINUS, 1'b0, '0},
    '{KIND_REMOTE, LEVEL_TOP, LEVEL_TOP, LEVEL_TOP, CODE_UNUSED, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_MENU, 1'b0, '0},
    '{KIND_TICK,   10'd0, LEVEL_TOP, 10'd0, CODE_MENU, 1'b0, '0},
    '{KIND_REMOTE, 10'd0, 10'd0, 10'd0, CODE_MENU, 1'b0, '0},
    '{KIND_TICK,   10'd100, 10'd101, 10'd100, CODE_REW, 1'b0, '0},
    '{KIND_TICK,   10'd101, 10'd100, 10'd1022, CODE_FWD, 1'b0, '0}
  };

  // Register settings per random phase: defaults first, then extremes and short holds
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 165;
  localparam reg_set_t REG_PHASES [0:PHASES-1] = '{
    '{LEVEL_THRESHOLD_RST, AMP_HOLD_TICKS_RST, VOLUME_MIN_RST, VOLUME_MAX_RST,
      VOLUME_START_RST},
    '{10'd0, 16'd0, 8'd0, 8'd255, 8'd255},
    '{10'd1023, 16'd2, 8'd255, 8'd0, 8'd0},
    '{10'd512, 16'd3, 8'd40, 8'd50, 8'd128},
    '{10'd700, 16'd1, 8'd10, 8'd20, 8'd7},
    '{10'd300, 16'd65535, 8'd50, 8'd200, 8'd90}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  asel_in_if  in_ch ();
  asel_out_if out_ch ();

  audio_source_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted selector state and register copies
  logic [NUM_CHANNELS-1:0] act_mask, last_mask, closed_relays;
  logic [CH_BITS-1:0]      cur_ch;
  logic                    amp_up, paused_now;
  logic [HOLD_BITS-1:0]    hold_left, hold_cfg;
  logic [VOL_BITS-1:0]     vol_now, vol_saved, vmin_cfg, vmax_cfg;
  logic [LEVEL_BITS-1:0]   thr_cfg;

  word_plan_t plan_q[$];
  out_item_t  expected_q[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 27;
  int take_idle_pct = 65;

  // Random stimulus memory: levels persist across ticks so the mask settles
  logic [LEVEL_BITS-1:0] lvl [0:2];
  logic vol_up = 1'b1;

  function automatic logic [CH_BITS-1:0] top_channel(logic [NUM_CHANNELS-1:0] m);
    logic [CH_BITS-1:0] n;
    n = NO_CHANNEL;
    for (int k = 0; k < NUM_CHANNELS; k++) if (m[k]) n = CH_BITS'(k);
    return n;
  endfunction

  // Close the relay of channel n, opening the current one
  task automatic move_to(logic [CH_BITS-1:0] n);
    if (cur_ch != NO_CHANNEL) closed_relays[cur_ch[1:0]] = 1'b0;
    closed_relays[n[1:0]] = 1'b1;
    hold_left = hold_cfg;
    cur_ch = {1'b0, n[1:0]};
  endtask

  // Advance the predicted state by one accepted word and return the result word
  task automatic predict_selector(input in_item_t w, output out_item_t res);
    logic [NUM_CHANNELS-1:0] change, fresh;
    logic [CH_BITS-1:0] n;
    if (w.kind == KIND_TICK) begin
      act_mask = {1'b0, w.level_c > thr_cfg, w.level_b > thr_cfg, w.level_a > thr_cfg};
      change = act_mask ^ last_mask;
      if (change != '0) begin
        if (cur_ch != NO_CHANNEL) begin
          closed_relays[cur_ch[1:0]] = 1'b0;
          cur_ch = NO_CHANNEL;
        end
        if (act_mask == '0) begin
          closed_relays = '0;
        end else begin
          fresh = change & act_mask;
          n = top_channel((fresh != '0) ? fresh : act_mask);
          closed_relays[n[1:0]] = 1'b1;
          hold_left = hold_cfg;
          cur_ch = n;
        end
        last_mask = act_mask;
      end
      if (act_mask != '0 && amp_up) hold_left = hold_cfg;
      else if (hold_left != '0) hold_left = hold_left - 1'b1;
      if (hold_left != '0) begin
        amp_up = 1'b1;
      end else begin
        amp_up = 1'b0;
        closed_relays = '0;
      end
    end else begin
      case (w.remote_code)
        CODE_REW: begin
          if (cur_ch != NO_CHANNEL && cur_ch != 3'd0) begin
            n = cur_ch - 3'd1;
            while (n != 3'd0 && !act_mask[n[1:0]]) n = n - 3'd1;
            if (n != 3'd0 || act_mask[0]) move_to(n);
          end
        end
        CODE_FWD: begin
          if (cur_ch < 3'd3) begin
            n = cur_ch + 3'd1;
            while (n < 3'd3 && !act_mask[n[1:0]]) n = n + 3'd1;
            if (n != 3'd3 || act_mask[3]) move_to(n);
          end
        end
        CODE_PLUS: begin
          paused_now = 1'b0;
          if (vol_now < vmax_cfg) begin
            vol_now = vol_now + 1'b1;
            vol_saved = vol_now;
          end
        end
        CODE_MINUS: begin
          paused_now = 1'b0;
          if (vol_now > vmin_cfg) begin
            vol_now = vol_now - 1'b1;
            vol_saved = vol_now;
          end
        end
        CODE_PLAY: begin
          if (paused_now) begin
            paused_now = 1'b0;
            vol_now = vol_saved;
          end else begin
            paused_now = 1'b1;
            vol_saved = vol_now;
            vol_now = vmin_cfg;
          end
        end
        CODE_MENU: begin
          if (amp_up) begin
            amp_up = 1'b0;
            hold_left = '0;
          end else begin
            n = top_channel(act_mask);
            if (n != NO_CHANNEL) begin
              amp_up = 1'b1;
              closed_relays[n[1:0]] = 1'b1;
              hold_left = hold_cfg;
              cur_ch = n;
            end
          end
        end
        default: ;
      endcase
    end
    res.relay_mask       = closed_relays;
    res.amp_enable       = amp_up;
    res.selected_channel = cur_ch;
    res.volume_position  = vol_now;
    res.paused           = paused_now;
  endtask

  // Track accepted input words and queue their expected result words
  always @(posedge clk) begin : track_inputs
    word_plan_t plan;
    out_item_t  predicted;
    if (in_ch.valid && in_ch.ready) begin
      plan = plan_q.pop_front();
      predict_selector(in_ch.data, predicted);
      expected_q.push_back(plan.typed ? plan.want : predicted);
    end
  end

  task automatic note_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation: %p", out_ch.data);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        note_field("relay_mask", 32'(want.relay_mask), 32'(out_ch.data.relay_mask));
        note_field("amp_enable", 32'(want.amp_enable), 32'(out_ch.data.amp_enable));
        note_field("selected_channel", 32'(want.selected_channel),
                   32'(out_ch.data.selected_channel));
        note_field("volume_position", 32'(want.volume_position),
                   32'(out_ch.data.volume_position));
        note_field("paused", 32'(want.paused), 32'(out_ch.data.paused));
      end
    end
  end

  // Stall the result side at random
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // Offer one word, holding valid until accepted
  task automatic send_word(in_item_t w, logic typed, out_item_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    plan_q.push_back('{typed, want});
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait for every outstanding result word
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // Write all registers; volume_start only matters at a reset, so prediction ignores it
  task automatic load_settings(reg_set_t s);
    put_reg(CFG_LEVEL_THRESHOLD, CFG_DATA_BITS'(s.thr));
    put_reg(CFG_AMP_HOLD_TICKS, s.hold);
    put_reg(CFG_VOLUME_MIN, CFG_DATA_BITS'(s.vmin));
    put_reg(CFG_VOLUME_MAX, CFG_DATA_BITS'(s.vmax));
    put_reg(CFG_VOLUME_START, CFG_DATA_BITS'(s.vstart));
    cfg_we <= 1'b0;
    thr_cfg  = s.thr;
    hold_cfg = s.hold;
    vmin_cfg = s.vmin;
    vmax_cfg = s.vmax;
  endtask

  // Pick a level: silent, full scale, around the threshold or anywhere
  function automatic logic [LEVEL_BITS-1:0] pick_level(logic [LEVEL_BITS-1:0] thr);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 5) return LEVEL_TOP;
    if (r < 7) begin
      v = int'(thr) + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return LEVEL_BITS'(v);
    end
    return LEVEL_BITS'($urandom_range(0, 1023));
  endfunction

  // Build a random word; unused fields always carry random bits
  task automatic make_word(output in_item_t w);
    int r;
    logic [CODE_BITS-1:0] code;
    if ($urandom_range(0, 39) == 0) vol_up = !vol_up;
    if ($urandom_range(0, 19) == 0) begin
      for (int k = 0; k < 3; k++) lvl[k] = pick_level(thr_cfg);
    end else if ($urandom_range(0, 3) == 0) begin
      lvl[2'($urandom_range(0, 2))] = pick_level(thr_cfg);
    end
    r = $urandom_range(0, 99);
    if (r < 12) code = CODE_REW;
    else if (r < 24) code = CODE_FWD;
    else if (r < 44) code = vol_up ? CODE_PLUS : CODE_MINUS;
    else if (r < 52) code = vol_up ? CODE_MINUS : CODE_PLUS;
    else if (r < 64) code = CODE_PLAY;
    else if (r < 74) code = CODE_MENU;
    else code = CODE_BITS'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 55) begin
      w.kind        = KIND_TICK;
      w.level_a     = lvl[0];
      w.level_b     = lvl[1];
      w.level_c     = lvl[2];
      w.remote_code = CODE_BITS'($urandom_range(0, 255));
    end else begin
      w.kind        = KIND_REMOTE;
      w.level_a     = LEVEL_BITS'($urandom_range(0, 1023));
      w.level_b     = LEVEL_BITS'($urandom_range(0, 1023));
      w.level_c     = LEVEL_BITS'($urandom_range(0, 1023));
      w.remote_code = code;
    end
  endtask

  initial begin : stimulus
    in_item_t w;
    int ph;
    int k;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_LEVEL_THRESHOLD;
    cfg_wdata   = '0;
    for (k = 0; k < 3; k++) lvl[k] = '0;
    // Reset state of the predictor
    act_mask      = '0;
    last_mask     = '0;
    closed_relays = '0;
    cur_ch        = NO_CHANNEL;
    amp_up        = 1'b0;
    paused_now    = 1'b0;
    hold_left     = '0;
    vol_now       = VOLUME_START_RST;
    vol_saved     = VOLUME_START_RST;
    thr_cfg       = LEVEL_THRESHOLD_RST;
    hold_cfg      = AMP_HOLD_TICKS_RST;
    vmin_cfg      = VOLUME_MIN_RST;
    vmax_cfg      = VOLUME_MAX_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table with reset register values
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      w.kind        = DIRECTED[k].kind;
      w.level_a     = DIRECTED[k].lv_a;
      w.level_b     = DIRECTED[k].lv_b;
      w.level_c     = DIRECTED[k].lv_c;
      w.remote_code = DIRECTED[k].code;
      send_word(w, DIRECTED[k].typed, DIRECTED[k].want);
    end

    // Random phases, each under its own register setting, with an idling mix per pair of phases
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 65 : 0;
      take_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 27 : 0;
      load_settings(REG_PHASES[ph]);
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        make_word(w);
        send_word(w, 1'b0, '0);
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
